/* rtl/core/load_cell_channel_supervisor_core_assert.svh */
// Assertion macros shared by the load-cell supervisor RTL.
// No dependencies; pulled in by the modules that check their own logic.
`ifndef LOAD_CELL_CHANNEL_SUPERVISOR_CORE_ASSERT_SVH
`define LOAD_CELL_CHANNEL_SUPERVISOR_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define LCCS_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define LCCS_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/core/lccs_pkg.sv */
// Shared types and constants for the load-cell channel supervisor.
// No dependencies; imported by every module of the block.
package lccs_pkg;

   localparam int RAW_W     = 24;
   localparam int FORCE_W   = 25;
   localparam int INDEX_W   = 32;
   localparam int RETRY_W   = 3;
   localparam int MODE_W    = 2;
   localparam int CSR_IDX_W = 2;
   localparam int DIV_W     = RAW_W;
   localparam int DIV_CNT_W = $clog2(DIV_W + 1);

   localparam logic [RETRY_W-1:0] RETRY_MAX = 3'd7;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ZERO_OFFSET     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COUNTS_PER_UNIT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RETRY_LIMIT     = 2'd2;

   localparam logic [RAW_W-1:0]   RST_ZERO_OFFSET     = 24'd0;
   localparam logic [RAW_W-1:0]   RST_COUNTS_PER_UNIT = 24'd1;
   localparam logic [RETRY_W-1:0] RST_RETRY_LIMIT     = 3'd3;

   typedef enum logic [MODE_W-1:0] {
      MODE_INIT = 2'd0,
      MODE_RUN  = 2'd1,
      MODE_ERR  = 2'd2
   } chan_mode_type;

   typedef struct packed {
      logic [RAW_W-1:0]   zero_offset;
      logic [RAW_W-1:0]   counts_per_unit;
      logic [RETRY_W-1:0] retry_limit;
   } cfg_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

/* rtl/core/lccs_csr.sv */
// Configuration registers: zero offset, gain divisor and retry limit.
// Depends on lccs_pkg.
module lccs_csr
   import lccs_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [RAW_W-1:0]     csr_wdata,
   output cfg_type              cfg
);

   cfg_type cfg_ff;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.zero_offset     <= RST_ZERO_OFFSET;
         cfg_ff.counts_per_unit <= RST_COUNTS_PER_UNIT;
         cfg_ff.retry_limit     <= RST_RETRY_LIMIT;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_ZERO_OFFSET:     cfg_ff.zero_offset     <= csr_wdata;
            CSR_COUNTS_PER_UNIT: cfg_ff.counts_per_unit <= csr_wdata;
            CSR_RETRY_LIMIT:     cfg_ff.retry_limit     <= csr_wdata[RETRY_W-1:0];
            default: ;
         endcase
      end
   end

endmodule

/* rtl/core/lccs_div.sv */
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on lccs_pkg and the assertion macro header.
`include "load_cell_channel_supervisor_core_assert.svh"

module lccs_div
   import lccs_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DIV_W-1:0] dividend,
   input  logic [DIV_W-1:0] divisor,
   output logic [DIV_W-1:0] quotient,
   output div_stat_type     stat
);

   logic [DIV_W-1:0]     rem_ff;
   logic [DIV_W-1:0]     quo_ff;
   logic [DIV_W-1:0]     dsr_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic                 done_ff;

   logic [DIV_W:0]   shifted;
   logic             ge;
   logic [DIV_W-1:0] rem_in;

   // shift in the next dividend bit, subtract if it fits
   always_comb begin
      shifted = {rem_ff, quo_ff[DIV_W-1]};
      ge      = (shifted >= {1'b0, dsr_ff});
      rem_in  = ge ? DIV_W'(shifted - {1'b0, dsr_ff}) : shifted[DIV_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            rem_ff <= '0;
            quo_ff <= dividend;
            dsr_ff <= divisor;
            cnt_ff <= DIV_CNT_W'(DIV_W);
         end else if (cnt_ff != '0) begin
            rem_ff  <= rem_in;
            quo_ff  <= {quo_ff[DIV_W-2:0], ge};
            cnt_ff  <= cnt_ff - 1'b1;
            done_ff <= (cnt_ff == DIV_CNT_W'(1));
         end
      end
   end

   assign quotient  = quo_ff;
   assign stat.busy = (cnt_ff != '0);
   assign stat.done = done_ff;

   `LCCS_ASSERT_IMP(a_start_idle, clock, reset, start, !stat.busy, "divider restarted while busy")
   `LCCS_ASSERT_NXT(a_start_busy, clock, reset, start, stat.busy, "divider did not start")
   `LCCS_ASSERT_IMP(a_done_idle, clock, reset, stat.done, !stat.busy, "done while still iterating")

endmodule

/* rtl/core/load_cell_channel_supervisor_core.sv */
// Load-cell channel supervisor: one tick in, one status beat out.
// A tick with no division to do (init, error, zero gain) goes from accept to
// S_DONE and then to the output register; in running it first waits in S_DIV
// for the 24-step divider. A new tick is taken only once back in S_IDLE.
// Synchronous active-high reset: all channels in init, config at defaults.
// Depends on lccs_pkg, lccs_csr, lccs_div and the assertion macro header.
`include "load_cell_channel_supervisor_core_assert.svh"

module load_cell_channel_supervisor_core
   import lccs_pkg::*;
#(
   parameter int CHANNELS = 2
)
(
   input  logic                      clock,
   input  logic                      reset,
   // tick input
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_channel,
   input  logic                      req_start_ok,
   input  logic                      req_conv_ok,
   input  logic [RAW_W-1:0]          req_raw_count,
   // status output
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic                      rsp_channel_out,
   output logic signed [FORCE_W-1:0] rsp_force_value,
   output logic [INDEX_W-1:0]        rsp_sample_index,
   output logic                      rsp_ready_res,
   output logic [MODE_W-1:0]         rsp_mode,
   output logic                      rsp_stop_request,
   // configuration
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_IDX_W-1:0]      csr_index,
   input  logic [RAW_W-1:0]          csr_wdata
);

   localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   typedef enum logic [1:0] {
      S_IDLE,
      S_DIV,
      S_DONE
   } seq_state_type;

   cfg_type      cfg;
   div_stat_type div_stat;
   logic [DIV_W-1:0] div_quo;
   logic             div_start;

   // per-channel state, flops (small depth, one read port)
   chan_mode_type             chan_mode_ff   [CHANNELS];
   logic                      chan_resp_ff   [CHANNELS];
   logic [RETRY_W-1:0]        chan_retry_ff  [CHANNELS];
   logic signed [FORCE_W-1:0] chan_force_ff  [CHANNELS];
   logic [INDEX_W-1:0]        chan_index_ff  [CHANNELS];
   logic                      chan_ready_ff  [CHANNELS];

   seq_state_type state_ff;

   // pending beat, built up while the divider runs
   logic                      pend_ch_ff;
   logic                      pend_neg_ff;
   logic signed [FORCE_W-1:0] pend_force_ff;
   logic [INDEX_W-1:0]        pend_index_ff;
   logic                      pend_ready_ff;
   chan_mode_type             pend_mode_ff;
   logic                      pend_stop_ff;
   logic                      pend_valid_ch_ff;

   // output register
   logic                      rsp_valid_ff;
   logic                      rsp_ch_ff;
   logic signed [FORCE_W-1:0] rsp_force_ff;
   logic [INDEX_W-1:0]        rsp_index_ff;
   logic                      rsp_ready_ff;
   logic [MODE_W-1:0]         rsp_mode_ff;
   logic                      rsp_stop_ff;

   // addressed channel
   logic [CH_IDX_W-1:0] ch_idx;
   logic [CH_IDX_W-1:0] pend_idx;
   logic                in_range;
   chan_mode_type       cur_mode;
   logic                cur_resp;
   logic [RETRY_W-1:0]  cur_retry;

   // next values for the addressed channel
   chan_mode_type       chan_mode_in;
   logic                chan_resp_in;
   logic [RETRY_W-1:0]  chan_retry_in;
   logic [INDEX_W-1:0]  chan_index_in;
   logic                chan_ready_in;
   logic                stop_in;

   logic                raw_above;
   logic [RAW_W-1:0]    magnitude;
   logic                need_div;
   logic                accept;
   logic                out_free;
   logic signed [FORCE_W-1:0] force_in;

   lccs_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   lccs_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (magnitude),
      .divisor  (cfg.counts_per_unit),
      .quotient (div_quo),
      .stat     (div_stat)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign ch_idx    = CH_IDX_W'(req_channel);
   assign pend_idx  = CH_IDX_W'(pend_ch_ff);
   assign in_range  = (32'(req_channel) < CHANNELS);
   assign cur_mode  = chan_mode_ff[ch_idx];
   assign cur_resp  = chan_resp_ff[ch_idx];
   assign cur_retry = chan_retry_ff[ch_idx];

   // mode transition uses the responding flag from the channel's last tick
   always_comb begin
      chan_mode_in  = cur_mode;
      chan_resp_in  = cur_resp;
      chan_retry_in = cur_retry;
      chan_index_in = chan_index_ff[ch_idx];
      chan_ready_in = chan_ready_ff[ch_idx];
      stop_in       = 1'b0;
      case (cur_mode)
         MODE_INIT: begin
            if (req_start_ok) chan_mode_in = MODE_RUN;
         end
         MODE_RUN: begin
            if (!cur_resp) chan_mode_in = MODE_ERR;
         end
         MODE_ERR: begin
            if (cur_resp) begin
               chan_mode_in  = MODE_RUN;
               chan_retry_in = '0;
            end else if (cur_retry > cfg.retry_limit) begin
               // retries used up: back to init and ask for an ADC stop
               chan_mode_in  = MODE_INIT;
               chan_retry_in = '0;
               stop_in       = 1'b1;
            end else if (cur_retry < RETRY_MAX) begin
               chan_retry_in = cur_retry + 1'b1;
            end
         end
         default: ;
      endcase
      // action of the new mode
      case (chan_mode_in)
         MODE_INIT: chan_ready_in = 1'b0;
         MODE_RUN: begin
            chan_resp_in  = req_conv_ok;
            chan_index_in = chan_index_ff[ch_idx] + 1'b1;
            chan_ready_in = 1'b1;
         end
         MODE_ERR: begin
            chan_resp_in  = req_conv_ok;
            chan_ready_in = 1'b0;
         end
         default: ;
      endcase
   end

   // |raw - offset|, sign kept aside; raw_count is used even on a stale conversion
   assign raw_above = (req_raw_count > cfg.zero_offset);
   assign magnitude = raw_above ? (req_raw_count - cfg.zero_offset)
                                : (cfg.zero_offset - req_raw_count);
   assign need_div  = in_range && (chan_mode_in == MODE_RUN)
                      && (cfg.counts_per_unit != '0);
   assign div_start = accept && need_div;
   assign force_in  = pend_neg_ff ? -$signed({1'b0, div_quo})
                                  : $signed({1'b0, div_quo});

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < CHANNELS; i++) begin
            chan_mode_ff[i]  <= MODE_INIT;
            chan_resp_ff[i]  <= 1'b0;
            chan_retry_ff[i] <= '0;
            chan_force_ff[i] <= '0;
            chan_index_ff[i] <= '0;
            chan_ready_ff[i] <= 1'b0;
         end
      end else begin
         // beat taken and nothing new to load behind it
         if (rsp_valid_ff && !rsp_stall && (state_ff != S_DONE)) rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  pend_ch_ff       <= req_channel;
                  pend_neg_ff      <= !raw_above;
                  pend_valid_ch_ff <= in_range;
                  pend_stop_ff     <= in_range && stop_in;
                  if (in_range) begin
                     chan_mode_ff[ch_idx]  <= chan_mode_in;
                     chan_resp_ff[ch_idx]  <= chan_resp_in;
                     chan_retry_ff[ch_idx] <= chan_retry_in;
                     chan_index_ff[ch_idx] <= chan_index_in;
                     chan_ready_ff[ch_idx] <= chan_ready_in;
                     pend_mode_ff          <= chan_mode_in;
                     pend_index_ff         <= chan_index_in;
                     pend_ready_ff         <= chan_ready_in;
                     if (chan_mode_in == MODE_RUN) begin
                        // zero gain reads as zero force; otherwise overwritten later
                        chan_force_ff[ch_idx] <= '0;
                        pend_force_ff         <= '0;
                     end else begin
                        pend_force_ff <= chan_force_ff[ch_idx];
                     end
                  end else begin
                     pend_mode_ff  <= MODE_INIT;
                     pend_index_ff <= '0;
                     pend_ready_ff <= 1'b0;
                     pend_force_ff <= '0;
                  end
                  state_ff <= need_div ? S_DIV : S_DONE;
               end
            end
            S_DIV: begin
               if (div_stat.done) begin
                  chan_force_ff[pend_idx] <= force_in;
                  pend_force_ff           <= force_in;
                  state_ff                <= S_DONE;
               end
            end
            S_DONE: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_ch_ff    <= pend_ch_ff;
                  rsp_force_ff <= pend_force_ff;
                  rsp_index_ff <= pend_index_ff;
                  rsp_ready_ff <= pend_ready_ff;
                  rsp_mode_ff  <= pend_valid_ch_ff ? MODE_W'(pend_mode_ff) : '0;
                  rsp_stop_ff  <= pend_stop_ff;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_channel_out  = rsp_ch_ff;
   assign rsp_force_value  = rsp_force_ff;
   assign rsp_sample_index = rsp_index_ff;
   assign rsp_ready_res    = rsp_ready_ff;
   assign rsp_mode         = rsp_mode_ff;
   assign rsp_stop_request = rsp_stop_ff;

   `LCCS_ASSERT_IMP(a_done_in_div, clock, reset, div_stat.done, state_ff == S_DIV, "divider done outside divide")
   `LCCS_ASSERT_IMP(a_div_working, clock, reset, state_ff == S_DIV, div_stat.busy || div_stat.done, "waiting on an idle divider")
   `LCCS_ASSERT_NXT(a_busy_after_beat, clock, reset, accept, req_stall, "took a second tick while busy")

endmodule

/* tb/tb.sv */
// Self-checking testbench for the load-cell channel supervisor core.
// Needs lccs_pkg and load_cell_channel_supervisor_core; stimulus is random
// with a directed opening, and an in-bench model predicts every status beat.
`timescale 1ns / 100ps

module tb
   import lccs_pkg::*;
();

   localparam int CHAN_COUNT = 2;

   // One polling tick as driven on the req_ channel.
   typedef struct packed {
      logic             channel;
      logic             start_ok;
      logic             conv_ok;
      logic [RAW_W-1:0] raw_count;
   } gauge_tick_type;

   // One status beat as seen on the rsp_ channel.
   typedef struct packed {
      logic                      channel_out;
      logic signed [FORCE_W-1:0] force_value;
      logic [INDEX_W-1:0]        sample_index;
      logic                      ready_res;
      chan_mode_type             mode;
      logic                      stop_request;
   } gauge_status_type;

   typedef enum int {
      BURST_HEALTHY,
      BURST_DROPOUT,
      BURST_NOISE
   } burst_kind_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic                      req_channel = 1'b0;
   logic                      req_start_ok = 1'b0;
   logic                      req_conv_ok = 1'b0;
   logic [RAW_W-1:0]          req_raw_count = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic                      rsp_channel_out;
   logic signed [FORCE_W-1:0] rsp_force_value;
   logic [INDEX_W-1:0]        rsp_sample_index;
   logic                      rsp_ready_res;
   logic [MODE_W-1:0]         rsp_mode;
   logic                      rsp_stop_request;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_IDX_W-1:0]      csr_index = CSR_ZERO_OFFSET;
   logic [RAW_W-1:0]          csr_wdata = '0;

   // Shadow of the per-channel state and of the configuration registers
   chan_mode_type             gauge_mode [CHAN_COUNT];
   logic                      responding [CHAN_COUNT];
   logic [RETRY_W-1:0]        retries    [CHAN_COUNT];
   logic signed [FORCE_W-1:0] held_force [CHAN_COUNT];
   logic [INDEX_W-1:0]        samples    [CHAN_COUNT];
   logic                      ready_flag [CHAN_COUNT];
   cfg_type                   gauge_cfg;

   gauge_status_type pending_status [$];
   gauge_status_type oldest_status;
   int unsigned      fail_count = 0;
   bit               sender_gapless = 1'b0;

   load_cell_channel_supervisor_core #(
      .CHANNELS (CHAN_COUNT)
   ) i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_channel      (req_channel),
      .req_start_ok     (req_start_ok),
      .req_conv_ok      (req_conv_ok),
      .req_raw_count    (req_raw_count),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_channel_out  (rsp_channel_out),
      .rsp_force_value  (rsp_force_value),
      .rsp_sample_index (rsp_sample_index),
      .rsp_ready_res    (rsp_ready_res),
      .rsp_mode         (rsp_mode),
      .rsp_stop_request (rsp_stop_request),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Hard stop: ends the run with a failure if the stimulus has not finished.
   initial begin
      #10_000_000;
      $display("tb: failure");
      $finish;
   end

   // Idle length: half the time none, mostly short, now and then long.
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Raw counts: rails, a band around the zero offset, or anything at all.
   function automatic logic [RAW_W-1:0] pick_raw();
      int unsigned r;
      r = $urandom_range(0, 9);
      if (r == 0) return '0;
      if (r == 1) return '1;
      if (r < 5) return gauge_cfg.zero_offset + RAW_W'($urandom_range(0, 64)) - RAW_W'(32);
      return RAW_W'($urandom);
   endfunction

   function automatic void clear_shadow();
      for (int c = 0; c < CHAN_COUNT; c++) begin
         gauge_mode[c] = MODE_INIT;
         responding[c] = 1'b0;
         retries[c]    = '0;
         held_force[c] = '0;
         samples[c]    = '0;
         ready_flag[c] = 1'b0;
      end
      gauge_cfg.zero_offset     = RST_ZERO_OFFSET;
      gauge_cfg.counts_per_unit = RST_COUNTS_PER_UNIT;
      gauge_cfg.retry_limit     = RST_RETRY_LIMIT;
   endfunction

   // Advances the shadow by one tick and returns the status beat it implies.
   // The channel port is one bit wide, so every tick lands on a real channel.
   function automatic gauge_status_type supervise_tick(input gauge_tick_type t);
      gauge_status_type s;
      chan_mode_type    m;
      logic [RAW_W-1:0] mag;
      int               c;
      c = int'(t.channel);
      s.stop_request = 1'b0;
      m = gauge_mode[c];
      // mode moves on the responding flag left by the previous tick
      case (m)
         MODE_INIT: begin
            if (t.start_ok) m = MODE_RUN;
         end
         MODE_RUN: begin
            if (!responding[c]) m = MODE_ERR;
         end
         MODE_ERR: begin
            if (responding[c]) begin
               m = MODE_RUN;
               retries[c] = '0;
            end else if (retries[c] > gauge_cfg.retry_limit) begin
               m = MODE_INIT;
               retries[c] = '0;
               s.stop_request = 1'b1;
            end else if (retries[c] != RETRY_MAX) begin
               retries[c] = retries[c] + 1'b1;
            end
         end
         default: ;
      endcase
      gauge_mode[c] = m;
      case (m)
         MODE_INIT: ready_flag[c] = 1'b0;
         MODE_RUN: begin
            // raw count is taken even when the conversion was late
            responding[c] = t.conv_ok;
            if (gauge_cfg.counts_per_unit == '0) begin
               held_force[c] = '0;
            end else if (t.raw_count > gauge_cfg.zero_offset) begin
               mag = (t.raw_count - gauge_cfg.zero_offset) / gauge_cfg.counts_per_unit;
               held_force[c] = $signed({1'b0, mag});
            end else begin
               mag = (gauge_cfg.zero_offset - t.raw_count) / gauge_cfg.counts_per_unit;
               held_force[c] = -$signed({1'b0, mag});
            end
            samples[c]    = samples[c] + 1'b1;
            ready_flag[c] = 1'b1;
         end
         MODE_ERR: begin
            responding[c] = t.conv_ok;
            ready_flag[c] = 1'b0;
         end
         default: ;
      endcase
      s.channel_out  = t.channel;
      s.force_value  = held_force[c];
      s.sample_index = samples[c];
      s.ready_res    = ready_flag[c];
      s.mode         = m;
      return s;
   endfunction

   function automatic void compare_field(input string name, input logic [31:0] want,
                                         input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         fail_count++;
      end
   endfunction

   // Each accepted status beat against the oldest outstanding prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_status.size() == 0) begin
            $display("%0t: status beat with none expected, expected nothing, actual ch %0d",
                     $time, rsp_channel_out);
            fail_count++;
         end else begin
            oldest_status = pending_status.pop_front();
            compare_field("channel_out", 32'(oldest_status.channel_out), 32'(rsp_channel_out));
            compare_field("force_value", 32'(oldest_status.force_value), 32'(rsp_force_value));
            compare_field("sample_index", oldest_status.sample_index, rsp_sample_index);
            compare_field("ready_res", 32'(oldest_status.ready_res), 32'(rsp_ready_res));
            compare_field("mode", 32'(oldest_status.mode), 32'(rsp_mode));
            compare_field("stop_request", 32'(oldest_status.stop_request),
                          32'(rsp_stop_request));
         end
      end
   end

   // Receiver back-pressure; every free run waits on the clock so that the
   // stall never gets two assignments in one step. Odd long calm stretches.
   initial begin
      @(posedge clock);
      forever begin
         if ($urandom_range(0, 19) == 0)
            repeat ($urandom_range(100, 300)) @(posedge clock);
         else
            repeat (1 + pick_gap()) @(posedge clock);
         rsp_stall <= 1'b1;
         repeat (1 + pick_gap()) @(posedge clock);
         rsp_stall <= 1'b0;
      end
   end

   // Sends one tick. Valid is left high after the beat so that back-to-back
   // ticks never drop it; a gap or a drain is what lowers it.
   task automatic send_tick(input gauge_tick_type t);
      int unsigned gap;
      gap = sender_gapless ? 0 : pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_channel   <= t.channel;
      req_start_ok  <= t.start_ok;
      req_conv_ok   <= t.conv_ok;
      req_raw_count <= t.raw_count;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_status.push_back(supervise_tick(t));
   endtask

   task automatic send_fields(input logic ch, input logic start_ok, input logic conv_ok,
                              input logic [RAW_W-1:0] raw);
      send_tick('{ch, start_ok, conv_ok, raw});
   endtask

   // Hold the sender off until every predicted beat has come back.
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_status.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_beat(input logic [CSR_IDX_W-1:0] code, input logic [RAW_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= code;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   // All three registers in one burst, only once the block has gone quiet.
   task automatic write_config(input logic [RAW_W-1:0] offset, input logic [RAW_W-1:0] gain,
                               input logic [RETRY_W-1:0] limit);
      drain_results();
      csr_beat(CSR_ZERO_OFFSET, offset);
      csr_beat(CSR_COUNTS_PER_UNIT, gain);
      csr_beat(CSR_RETRY_LIMIT, RAW_W'(limit));
      csr_valid <= 1'b0;
      gauge_cfg.zero_offset     = offset;
      gauge_cfg.counts_per_unit = gain;
      gauge_cfg.retry_limit     = limit;
   endtask

   // Reset defaults: init hold, start-up, stale conversion, dropout and recovery,
   // and a second channel kept apart from the first.
   task automatic test_default_config();
      send_fields(1'b0, 1'b0, 1'b1, 24'h00007b);
      send_fields(1'b0, 1'b1, 1'b1, '1);
      send_fields(1'b0, 1'b0, 1'b0, '0);
      send_fields(1'b1, 1'b1, 1'b0, 24'h000001);
      send_fields(1'b0, 1'b1, 1'b1, 24'h000005);
      send_fields(1'b1, 1'b0, 1'b1, 24'h800000);
      send_fields(1'b0, 1'b0, 1'b1, 24'h000005);
   endtask

   // Force at the rails of offset and gain, and the zero-gain case.
   task automatic test_force_extremes();
      write_config('1, 24'd1, 3'd3);
      send_fields(1'b0, 1'b0, 1'b1, '0);
      send_fields(1'b0, 1'b0, 1'b1, '1);
      write_config('0, '1, 3'd3);
      send_fields(1'b0, 1'b1, 1'b1, '1);
      send_fields(1'b0, 1'b1, 1'b1, 24'hfffffe);
      write_config(24'h800000, '0, 3'd3);
      send_fields(1'b0, 1'b0, 1'b1, '0);
      send_fields(1'b0, 1'b0, 1'b0, '1);
   endtask

   // Limit 7: the retry count pins at its ceiling and the channel waits in
   // error until the gauge answers again.
   task automatic test_retry_saturation();
      write_config(24'h800000, 24'd7, 3'd7);
      for (int k = 0; k < 8; k++) send_fields(1'b0, 1'b1, 1'b0, RAW_W'($urandom));
      send_fields(1'b0, 1'b0, 1'b1, 24'h123456);
      send_fields(1'b0, 1'b0, 1'b0, '0);
   endtask

   // Limit 0: one retry and the channel drops back to init with a stop request.
   task automatic test_retry_exhaustion();
      write_config('0, 24'd3, 3'd0);
      for (int k = 0; k < 3; k++) send_fields(1'b0, 1'b0, 1'b0, 24'h000300);
      send_fields(1'b0, 1'b0, 1'b1, 24'h000300);
   endtask

   // Bursts on one channel with stray ticks on the other: mostly healthy
   // running, some dropouts long enough to spend the retries, some noise.
   task automatic test_random_ticks(input int unsigned count, input bit gapless);
      int unsigned    burst_left;
      logic           focus;
      burst_kind_type kind;
      gauge_tick_type t;
      int unsigned    r;
      burst_left = 0;
      focus = 1'b0;
      kind = BURST_HEALTHY;
      sender_gapless = gapless;
      for (int unsigned n = 0; n < count; n++) begin
         if (burst_left == 0) begin
            focus = 1'($urandom_range(0, 1));
            r = $urandom_range(0, 9);
            kind = (r < 5) ? BURST_HEALTHY : (r < 8) ? BURST_DROPOUT : BURST_NOISE;
            burst_left = $urandom_range(1, 12);
         end
         burst_left--;
         t.channel = ($urandom_range(0, 4) == 0) ? ~focus : focus;
         case (kind)
            BURST_HEALTHY: begin
               t.start_ok = ($urandom_range(0, 99) < 85);
               t.conv_ok  = ($urandom_range(0, 99) < 92);
            end
            BURST_DROPOUT: begin
               t.start_ok = 1'($urandom_range(0, 1));
               t.conv_ok  = ($urandom_range(0, 99) < 5);
            end
            default: begin
               t.start_ok = 1'($urandom_range(0, 1));
               t.conv_ok  = 1'($urandom_range(0, 1));
            end
         endcase
         t.raw_count = pick_raw();
         send_tick(t);
         if (n == count / 2) drain_results();
      end
      sender_gapless = 1'b0;
   endtask

   initial begin
      clear_shadow();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      test_default_config();
      test_force_extremes();
      test_retry_saturation();
      test_retry_exhaustion();

      // random phases, each under its own register setting
      write_config(RAW_W'($urandom), RAW_W'($urandom_range(1, 300)),
                   RETRY_W'($urandom_range(0, 7)));
      test_random_ticks(100, 1'b0);
      write_config('0, 24'd1, 3'd0);
      test_random_ticks(90, 1'b1);
      write_config('1, '1, 3'd7);
      test_random_ticks(80, 1'b0);
      write_config(RAW_W'($urandom), RAW_W'($urandom), RETRY_W'($urandom_range(0, 7)));
      test_random_ticks(100, 1'b0);
      write_config(RAW_W'($urandom), '0, RETRY_W'($urandom_range(0, 7)));
      test_random_ticks(40, 1'b1);
      write_config(RAW_W'($urandom), RAW_W'($urandom_range(1, 15)),
                   RETRY_W'($urandom_range(0, 7)));
      test_random_ticks(90, 1'b0);

      drain_results();
      repeat (40) @(posedge clock);
      if (fail_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/lccs_pkg.sv
rtl/core/lccs_csr.sv
rtl/core/lccs_div.sv
rtl/core/load_cell_channel_supervisor_core.sv
tb/tb.sv
